// ----- rtl/odh_pkg.sv -----
// shared types and constants for the orientation detector with hold
// no dependencies
package odh_pkg;

    localparam int AXIS_W  = 16;
    localparam int ROT_W   = AXIS_W + 1;
    localparam int THR_W   = 15;
    localparam int HOLD_W  = 24;
    localparam int TS_W    = 48;
    localparam int POSE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [THR_W-1:0]  ENTER_RESET = 15'd9830;
    localparam logic [THR_W-1:0]  FLAT_RESET  = 15'd13107;
    localparam logic [HOLD_W-1:0] HOLD_RESET  = 24'd500000;

    typedef enum logic [1:0] {
        REG_ENTER = 2'd0,
        REG_FLAT  = 2'd1,
        REG_HOLD  = 2'd2,
        REG_ROT   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [POSE_W-1:0] {
        POSE_FLAT  = 3'd0,
        POSE_UP    = 3'd1,
        POSE_DOWN  = 3'd2,
        POSE_RIGHT = 3'd3,
        POSE_LEFT  = 3'd4
    } pose_t;

    typedef struct packed {
        logic [THR_W-1:0]  enter_threshold;
        logic [THR_W-1:0]  flat_threshold;
        logic [HOLD_W-1:0] hold_time_us;
        rot_t              mount_rotation;
    } cfg_t;

    typedef struct packed {
        pose_t           cls;
        logic [TS_W-1:0] ts;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } head_t;

endpackage

// ----- rtl/odh_front.sv -----
// front stage: rotates x and y by the mount angle and classifies the sample
// depends on odh_pkg
module odh_front import odh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    input  logic [TS_W-1:0]          timestamp_us,
    output push_t                    push,
    input  logic                     q_full
);

    logic                    valid_reg;
    entry_t                  data_reg;
    logic                    load;
    logic signed [ROT_W-1:0] x17, y17, z17, az, sx, sy, en_pos, en_neg, flat17;
    pose_t                   cls;

    always_comb
    begin
        x17    = ROT_W'(accel_x);
        y17    = ROT_W'(accel_y);
        z17    = ROT_W'(accel_z);
        az     = z17[ROT_W-1] ? -z17 : z17;
        en_pos = signed'({2'b00, cfg.enter_threshold});
        en_neg = -en_pos;
        flat17 = signed'({2'b00, cfg.flat_threshold});
        case (cfg.mount_rotation)
            ROT_90:  begin sx = -y17; sy = x17;  end
            ROT_180: begin sx = -x17; sy = -y17; end
            ROT_270: begin sx = y17;  sy = -x17; end
            default: begin sx = x17;  sy = y17;  end
        endcase
        if (az > flat17)
            cls = POSE_FLAT;
        else if (sy > en_pos)
            cls = POSE_UP;
        else if (sy < en_neg)
            cls = POSE_DOWN;
        else if (sx > en_pos)
            cls = POSE_RIGHT;
        else if (sx < en_neg)
            cls = POSE_LEFT;
        else
            cls = POSE_FLAT;
    end

    // stage holds while the queue is full
    assign in_stall = valid_reg && q_full;
    assign load     = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg.cls <= cls;
            data_reg.ts  <= timestamp_us;
        end
    end

    assign push.valid = valid_reg && !q_full;
    assign push.data  = data_reg;

endmodule

// ----- rtl/odh_queue.sv -----
// short queue of classified requests between front and back
// depends on odh_pkg
module odh_queue import odh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    output head_t head,
    input  logic  pop
);

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push.valid, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.data;
    end

endmodule

// ----- rtl/odh_back.sv -----
// back stage: pending and adopted pose with hold timer, result register
// depends on odh_pkg
module odh_back import odh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [HOLD_W-1:0]   hold_time_us,
    input  head_t               head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [POSE_W-1:0]   adopted_pose,
    output logic [POSE_W-1:0]   instant_pose
);

    pose_t           current_reg, current_next;
    pose_t           pending_reg, pending_next;
    logic [TS_W-1:0] since_reg, since_next;
    logic [TS_W-1:0] elapsed;
    logic            valid_reg;
    pose_t           adopted_reg, instant_reg;

    assign pop     = head.valid && (!valid_reg || !out_stall);
    assign elapsed = head.data.ts - since_reg;

    always_comb
    begin
        current_next = current_reg;
        pending_next = pending_reg;
        since_next   = since_reg;
        if (head.data.cls == POSE_FLAT)
        begin
            pending_next = current_reg;
            since_next   = head.data.ts;
        end
        else if (head.data.cls != pending_reg)
        begin
            pending_next = head.data.cls;
            since_next   = head.data.ts;
        end
        else if (head.data.cls != current_reg
                 && elapsed >= TS_W'(hold_time_us))
        begin
            current_next = head.data.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= POSE_FLAT;
            pending_reg <= POSE_FLAT;
            since_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                current_reg <= current_next;
                pending_reg <= pending_next;
                since_reg   <= since_next;
                valid_reg   <= 1'b1;
            end
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            adopted_reg <= current_next;
            instant_reg <= head.data.cls;
        end
    end

    assign out_valid    = valid_reg;
    assign adopted_pose = adopted_reg;
    assign instant_pose = instant_reg;

endmodule

// ----- rtl/orientation_detector_with_hold_core.sv -----
// top level of the orientation detector with hold: register file and stages
// depends on odh_pkg, odh_front, odh_queue, odh_back
//
// Takes one accelerometer request per cycle while not stalled and returns one
// result per request, in order, with the adopted pose and the class of that
// sample alone. A request passes, in order, one front register, a four-entry
// queue and the result register; while nothing stalls, the sustained rate is
// one request per cycle. Registers sit at byte addresses 0 (enter threshold),
// 4 (flat threshold), 8 (hold time in microseconds) and 12 (mount rotation)
// and should be written only while no request is in flight.
module orientation_detector_with_hold_core import odh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    input  logic [TS_W-1:0]          timestamp_us,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [POSE_W-1:0]        adopted_pose,
    output logic [POSE_W-1:0]        instant_pose
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;
    push_t    push;
    head_t    head;
    logic     q_full;
    logic     pop;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enter_threshold <= ENTER_RESET;
            cfg_reg.flat_threshold  <= FLAT_RESET;
            cfg_reg.hold_time_us    <= HOLD_RESET;
            cfg_reg.mount_rotation  <= ROT_0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ENTER: cfg_reg.enter_threshold <= pwdata[THR_W-1:0];
                REG_FLAT:  cfg_reg.flat_threshold  <= pwdata[THR_W-1:0];
                REG_HOLD:  cfg_reg.hold_time_us    <= pwdata[HOLD_W-1:0];
                REG_ROT:   cfg_reg.mount_rotation  <= rot_t'(pwdata[1:0]);
                default:   cfg_reg.mount_rotation  <= cfg_reg.mount_rotation;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENTER: prdata = DATA_W'(cfg_reg.enter_threshold);
            REG_FLAT:  prdata = DATA_W'(cfg_reg.flat_threshold);
            REG_HOLD:  prdata = DATA_W'(cfg_reg.hold_time_us);
            REG_ROT:   prdata = DATA_W'(cfg_reg.mount_rotation);
            default:   prdata = '0;
        endcase
    end

    odh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .timestamp_us (timestamp_us),
        .push         (push),
        .q_full       (q_full)
    );

    odh_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    odh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold_time_us (cfg_reg.hold_time_us),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .adopted_pose (adopted_pose),
        .instant_pose (instant_pose)
    );

endmodule
